[rtl/bitmap_cluster_allocator_macros.svh]
// Assertion macros shared by the allocator RTL.
// Expects clk and arst_n in the including module.
`ifndef BITMAP_CLUSTER_ALLOCATOR_MACROS_SVH
`define BITMAP_CLUSTER_ALLOCATOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BCA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define BCA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/bca_pkg.sv]
// Package for the bitmap cluster allocator: sizes, codes, word and control structs.
// No dependencies.
`timescale 1ns / 1ps

package bca_pkg;

	localparam int MAP_BITS  = 4096;
	localparam int WORD_BITS = 32;
	localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int WADDR_W   = $clog2(MAP_WORDS);
	localparam int IDX_W     = 12;
	localparam int LIM_W     = 13;
	localparam int FUNC_W    = 2;
	localparam int STAT_W    = 2;

	localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(MAP_BITS);
	localparam logic [LIM_W-1:0] LIMIT_MAX   = LIM_W'(MAP_BITS);

	localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
	localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_MARK  = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [IDX_W-1:0]  cluster_index;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0]  granted_index;
	} rsp_t;

	typedef struct packed {
		logic              load_req;
		logic              rd_en;
		logic              rd_scan;
		logic              wr_en;
		logic              fin;
		logic              fin_found;
		logic [STAT_W-1:0] fin_status;
	} cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              lim_zero;
		logic              out_of_range;
		logic              found;
		logic              last_word;
	} sts_t;

endpackage

[rtl/bitmap_cluster_allocator.sv]
// Bitmap cluster allocator: first-fit allocate, free and mark-used over a usage bitmap.
// Top level; joins bca_controller and bca_datapath, uses bca_pkg.
`timescale 1ns / 1ps
//
// Request channel: req (func, cluster_index) is taken at a rising edge with start
// high and busy low. busy stays high until the result is issued.
// Result channel: rsp (status, granted_index) is valid for exactly one cycle while
// done is high; the receiver cannot stall it. A new request may be taken in the
// same cycle done is high.
// Configuration: cfg_we writes cfg_data into cluster_limit at the clock edge;
// write only while idle.
// Sequence from accept to done: func 3, out-of-range or zero limit finish in the
// check state; free and mark-used take one memory read and one write-back;
// allocate scans w bitmap words (1 to 128), one word per cycle
// through the single read port of the bitmap memory.
// Reset: cluster_limit returns to 4096 and the bitmap reads as all free at once,
// through per-word valid flops; no clearing pass.

module bitmap_cluster_allocator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  bca_pkg::req_t             req,
	output logic                      done,
	output bca_pkg::rsp_t             rsp,
	input  logic                      cfg_we,
	input  logic [bca_pkg::LIM_W-1:0] cfg_data
);

	bca_pkg::cmd_t cmd;
	bca_pkg::sts_t sts;

	bca_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (sts),
		.cmd    (cmd)
	);

	bca_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.rsp      (rsp)
	);

endmodule

[rtl/bca_datapath.sv]
// Datapath of the bitmap cluster allocator: request and limit registers, bitmap
// memory with per-word valid bits, free-bit search and result register. Uses bca_pkg.
`timescale 1ns / 1ps
`include "bitmap_cluster_allocator_macros.svh"

module bca_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  bca_pkg::req_t    req,
	input  logic             cfg_we,
	input  logic [bca_pkg::LIM_W-1:0] cfg_data,
	input  bca_pkg::cmd_t    cmd,
	output bca_pkg::sts_t    sts,
	output bca_pkg::rsp_t    rsp
);

	localparam int LWORD_W = bca_pkg::LIM_W - bca_pkg::BIT_W;

	bca_pkg::req_t                     req_q;
	bca_pkg::rsp_t                     rsp_q;
	logic [bca_pkg::LIM_W-1:0]         limit_q;
	logic [bca_pkg::WADDR_W-1:0]       scan_q;
	logic [bca_pkg::MAP_WORDS-1:0]     valid_q;
	logic [bca_pkg::WORD_BITS-1:0]     mem [bca_pkg::MAP_WORDS];
	logic [bca_pkg::WORD_BITS-1:0]     rd_mem_s1;
	logic                              rd_vld_s1;
	logic [bca_pkg::WADDR_W-1:0]       addr_s1;

	logic [bca_pkg::LIM_W-1:0]         lim_eff;
	logic [bca_pkg::LIM_W-1:0]         lim_m1;
	logic [bca_pkg::WADDR_W-1:0]       rd_addr;
	logic [bca_pkg::WADDR_W-1:0]       idx_word;
	logic [bca_pkg::BIT_W-1:0]         idx_bit;
	logic [bca_pkg::WORD_BITS-1:0]     rdata;
	logic [bca_pkg::WORD_BITS-1:0]     avail;
	logic [bca_pkg::WORD_BITS-1:0]     free_bits;
	logic [bca_pkg::BIT_W-1:0]         free_pos;
	logic [bca_pkg::BIT_W-1:0]         wr_bit;
	logic [bca_pkg::WORD_BITS-1:0]     wr_mask;
	logic [bca_pkg::WORD_BITS-1:0]     wdata;
	logic [LWORD_W-1:0]                cur_word;

	assign lim_eff  = (limit_q > bca_pkg::LIMIT_MAX) ? bca_pkg::LIMIT_MAX : limit_q;
	assign lim_m1   = lim_eff - bca_pkg::LIM_W'(1);
	assign idx_word = req_q.cluster_index[bca_pkg::IDX_W-1:bca_pkg::BIT_W];
	assign idx_bit  = req_q.cluster_index[bca_pkg::BIT_W-1:0];
	assign rd_addr  = cmd.rd_scan ? scan_q : idx_word;
	assign rdata    = rd_vld_s1 ? rd_mem_s1 : '0;
	assign cur_word = LWORD_W'(addr_s1);

	always_comb begin
		for (int b = 0; b < bca_pkg::WORD_BITS; b++) begin
			avail[b] = (cur_word < lim_eff[bca_pkg::LIM_W-1:bca_pkg::BIT_W]) ||
				((cur_word == lim_eff[bca_pkg::LIM_W-1:bca_pkg::BIT_W]) &&
				(bca_pkg::BIT_W'(b) < lim_eff[bca_pkg::BIT_W-1:0]));
		end
	end

	assign free_bits = ~rdata & avail;

	always_comb begin
		free_pos = '0;
		for (int b = bca_pkg::WORD_BITS - 1; b >= 0; b--) begin
			if (free_bits[b]) begin
				free_pos = bca_pkg::BIT_W'(b);
			end
		end
	end

	assign wr_bit  = (req_q.func == bca_pkg::FN_ALLOC) ? free_pos : idx_bit;
	assign wr_mask = bca_pkg::WORD_BITS'(1) << wr_bit;
	assign wdata   = (req_q.func == bca_pkg::FN_FREE) ? (rdata & ~wr_mask) : (rdata | wr_mask);

	assign sts.func         = req_q.func;
	assign sts.lim_zero     = (lim_eff == '0);
	assign sts.out_of_range = ({1'b0, req_q.cluster_index} >= lim_eff);
	assign sts.found        = |free_bits;
	assign sts.last_word    = (addr_s1 == lim_m1[bca_pkg::BIT_W +: bca_pkg::WADDR_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= bca_pkg::LIMIT_RESET;
			valid_q <= '0;
			scan_q  <= '0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (cmd.wr_en) begin
				valid_q[addr_s1] <= 1'b1;
			end
			if (cmd.load_req) begin
				scan_q <= '0;
			end else if (cmd.rd_en && cmd.rd_scan) begin
				scan_q <= scan_q + bca_pkg::WADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[addr_s1] <= wdata;
		end
		if (cmd.rd_en) begin
			rd_mem_s1 <= mem[rd_addr];
			rd_vld_s1 <= valid_q[rd_addr];
			addr_s1   <= rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req;
		end
		if (cmd.fin) begin
			rsp_q.status        <= cmd.fin_status;
			rsp_q.granted_index <= cmd.fin_found ?
				bca_pkg::IDX_W'({addr_s1, free_pos}) : req_q.cluster_index;
		end
	end

	assign rsp = rsp_q;

	`BCA_ASSERT_NOW(a_rw_apart, cmd.wr_en && cmd.rd_en, rd_addr != addr_s1, "read hits word being written")
	`BCA_ASSERT_NOW(a_grant_found, cmd.fin && cmd.fin_found, sts.found, "grant without a free bit")

endmodule

[rtl/bca_controller.sv]
// Controller of the bitmap cluster allocator: sequences accept, check, scan and
// read-modify-write, and raises the done strobe. Uses bca_pkg.
`timescale 1ns / 1ps
`include "bitmap_cluster_allocator_macros.svh"

module bca_controller (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	input  bca_pkg::sts_t sts,
	output bca_pkg::cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CHK  = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_MOD  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load_req = 1'b1;
					state_d      = S_CHK;
				end
			end
			S_CHK: begin
				unique case (sts.func) inside
					bca_pkg::FN_ALLOC: begin
						if (sts.lim_zero) begin
							cmd.fin        = 1'b1;
							cmd.fin_status = bca_pkg::ST_FULL;
							state_d        = S_IDLE;
						end else begin
							cmd.rd_en   = 1'b1;
							cmd.rd_scan = 1'b1;
							state_d     = S_SCAN;
						end
					end
					bca_pkg::FN_FREE, bca_pkg::FN_MARK: begin
						if (sts.out_of_range) begin
							cmd.fin        = 1'b1;
							cmd.fin_status = bca_pkg::ST_RANGE;
							state_d        = S_IDLE;
						end else begin
							cmd.rd_en = 1'b1;
							state_d   = S_MOD;
						end
					end
					default: begin
						cmd.fin        = 1'b1;
						cmd.fin_status = bca_pkg::ST_OK;
						state_d        = S_IDLE;
					end
				endcase
			end
			S_SCAN: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_scan = 1'b1;
				if (sts.found) begin
					cmd.wr_en      = 1'b1;
					cmd.fin        = 1'b1;
					cmd.fin_found  = 1'b1;
					cmd.fin_status = bca_pkg::ST_OK;
					state_d        = S_IDLE;
				end else if (sts.last_word) begin
					cmd.fin        = 1'b1;
					cmd.fin_status = bca_pkg::ST_FULL;
					state_d        = S_IDLE;
				end
			end
			S_MOD: begin
				cmd.wr_en      = 1'b1;
				cmd.fin        = 1'b1;
				cmd.fin_status = bca_pkg::ST_OK;
				state_d        = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.fin;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	`BCA_ASSERT_NOW(a_done_idle, done_q, state_q == S_IDLE, "done strobe outside idle")
	`BCA_ASSERT_NEXT(a_accept_chk, start && !busy, state_q == S_CHK, "accepted word not checked")

endmodule

[tb/bitmap_cluster_allocator_tb.sv]
// Testbench for bitmap_cluster_allocator: a directed table, then random words over several
// cluster limits, each checked against the table or a bit-level model of the usage bitmap.
// Depends on bca_pkg and the allocator RTL.
`timescale 1ns / 1ps

module bitmap_cluster_allocator_tb;

	import bca_pkg::*;

	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
	localparam int DIR_N = 30;
	localparam int PHASES = 9;
	localparam int WORDS_PER_PHASE = 50;
	localparam int TAIL_CYCLES = 140;

	typedef struct packed {
		logic             is_cfg;
		logic [LIM_W-1:0] cfg_val;
		req_t             word;
		logic             typed;
		rsp_t             want;
	} dir_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	req_t             req = '0;
	logic             done;
	rsp_t             rsp;
	logic             cfg_we = 1'b0;
	logic [LIM_W-1:0] cfg_data = '0;

	bit [MAP_BITS-1:0] used_map = '0;
	logic [LIM_W-1:0]  limit_reg = LIMIT_RESET;
	rsp_t              pending_grants[$];
	rsp_t              head_grant;
	int                mismatch_count = 0;

	dir_row_t dir_rows [DIR_N] = '{
		'{1'b0, 13'd0, '{FN_ALLOC, 12'hFFF}, 1'b1, '{ST_OK, 12'd0}},
		'{1'b0, 13'd0, '{FN_ALLOC, 12'h000}, 1'b1, '{ST_OK, 12'd1}},
		'{1'b0, 13'd0, '{FN_FREE, 12'h000}, 1'b1, '{ST_OK, 12'd0}},
		'{1'b0, 13'd0, '{FN_ALLOC, 12'h555}, 1'b1, '{ST_OK, 12'd0}},
		'{1'b0, 13'd0, '{FN_FREE, 12'hFFF}, 1'b1, '{ST_OK, 12'hFFF}},
		'{1'b0, 13'd0, '{FN_MARK, 12'hFFF}, 1'b1, '{ST_OK, 12'hFFF}},
		'{1'b0, 13'd0, '{FN_MARK, 12'hFFF}, 1'b1, '{ST_OK, 12'hFFF}},
		'{1'b0, 13'd0, '{FN_UNUSED, 12'hAAA}, 1'b1, '{ST_OK, 12'hAAA}},
		'{1'b0, 13'd0, '{FN_UNUSED, 12'h555}, 1'b1, '{ST_OK, 12'h555}},
		'{1'b0, 13'd0, '{FN_MARK, 12'h002}, 1'b1, '{ST_OK, 12'h002}},
		'{1'b0, 13'd0, '{FN_ALLOC, 12'h800}, 1'b0, '0},
		'{1'b1, 13'd4, '0, 1'b0, '0},
		'{1'b0, 13'd0, '{FN_ALLOC, 12'h123}, 1'b1, '{ST_FULL, 12'h123}},
		'{1'b0, 13'd0, '{FN_FREE, 12'h004}, 1'b1, '{ST_RANGE, 12'h004}},
		'{1'b0, 13'd0, '{FN_MARK, 12'hFFF}, 1'b1, '{ST_RANGE, 12'hFFF}},
		'{1'b0, 13'd0, '{FN_FREE, 12'h003}, 1'b0, '0},
		'{1'b0, 13'd0, '{FN_ALLOC, 12'h7FF}, 1'b0, '0},
		'{1'b1, 13'd0, '0, 1'b0, '0},
		'{1'b0, 13'd0, '{FN_ALLOC, 12'h0F0}, 1'b1, '{ST_FULL, 12'h0F0}},
		'{1'b0, 13'd0, '{FN_FREE, 12'h000}, 1'b1, '{ST_RANGE, 12'h000}},
		'{1'b0, 13'd0, '{FN_MARK, 12'hABC}, 1'b1, '{ST_RANGE, 12'hABC}},
		'{1'b1, 13'h1FFF, '0, 1'b0, '0},
		'{1'b0, 13'd0, '{FN_ALLOC, 12'h000}, 1'b0, '0},
		'{1'b0, 13'd0, '{FN_FREE, 12'hFFF}, 1'b1, '{ST_OK, 12'hFFF}},
		'{1'b0, 13'd0, '{FN_ALLOC, 12'hFFF}, 1'b0, '0},
		'{1'b1, 13'd1, '0, 1'b0, '0},
		'{1'b0, 13'd0, '{FN_ALLOC, 12'h3C3}, 1'b1, '{ST_FULL, 12'h3C3}},
		'{1'b0, 13'd0, '{FN_FREE, 12'h000}, 1'b1, '{ST_OK, 12'h000}},
		'{1'b0, 13'd0, '{FN_ALLOC, 12'h000}, 1'b0, '0},
		'{1'b1, LIMIT_RESET, '0, 1'b0, '0}
	};

	bitmap_cluster_allocator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int active_limit();
		return (limit_reg > LIMIT_MAX) ? MAP_BITS : int'(limit_reg);
	endfunction

	function automatic rsp_t grant_for(input req_t word);
		rsp_t res;
		int   lim;
		int   n;
		lim = active_limit();
		res.status = ST_OK;
		res.granted_index = word.cluster_index;
		case (word.func)
			FN_ALLOC: begin
				res.status = ST_FULL;
				for (n = 0; n < lim; n++) begin
					if (!used_map[n]) begin
						used_map[n] = 1'b1;
						res.status = ST_OK;
						res.granted_index = IDX_W'(n);
						break;
					end
				end
			end
			FN_FREE, FN_MARK: begin
				if (int'(word.cluster_index) >= lim)
					res.status = ST_RANGE;
				else
					used_map[word.cluster_index] = (word.func == FN_MARK);
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic idle_gap(input int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic send_word(input req_t word, input logic typed, input rsp_t want);
		rsp_t guess;
		req <= word;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		guess = grant_for(word);
		pending_grants.push_back(typed ? want : guess);
	endtask

	task automatic write_limit(input logic [LIM_W-1:0] value);
		start <= 1'b0;
		do @(posedge clk); while (pending_grants.size() != 0);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_reg = value;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_grants.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected word: expected none, actual status %0d index %0d",
					$time, rsp.status, rsp.granted_index);
			end else begin
				head_grant = pending_grants.pop_front();
				if (rsp.status !== head_grant.status) begin
					mismatch_count++;
					$display("%0t: status: expected %0d, actual %0d",
						$time, head_grant.status, rsp.status);
				end
				if (rsp.granted_index !== head_grant.granted_index) begin
					mismatch_count++;
					$display("%0t: granted_index: expected %0d, actual %0d",
						$time, head_grant.granted_index, rsp.granted_index);
				end
			end
		end
	end

	initial begin
		#6_000_000;
		$display("bitmap_cluster_allocator: mismatch");
		$finish;
	end

	initial begin
		int               i;
		int               p;
		int               k;
		int               r;
		int               lim;
		logic [LIM_W-1:0] phase_limit;
		req_t             word;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIR_N; i++) begin
			if (dir_rows[i].is_cfg) begin
				write_limit(dir_rows[i].cfg_val);
			end else begin
				idle_gap(pick_gap());
				send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: phase_limit = LIMIT_RESET;
				1: phase_limit = 13'd1;
				2: phase_limit = 13'd37;
				3: phase_limit = 13'h1FFF;
				4: phase_limit = LIM_W'($urandom_range(2, 200));
				5: phase_limit = 13'd0;
				6: phase_limit = 13'd4097;
				7: phase_limit = 13'd64;
				default: phase_limit = LIM_W'($urandom_range(1, MAP_BITS));
			endcase
			write_limit(phase_limit);
			lim = active_limit();
			for (k = 0; k < WORDS_PER_PHASE; k++) begin
				r = $urandom_range(0, 99);
				if (r < 40)
					word.func = FN_ALLOC;
				else if (r < 70)
					word.func = FN_FREE;
				else if (r < 90)
					word.func = FN_MARK;
				else
					word.func = FN_UNUSED;
				r = $urandom_range(0, 99);
				if (lim > 0 && r < 70) begin
					if (lim > 256 && r < 35)
						word.cluster_index = IDX_W'($urandom_range(0, 255));
					else
						word.cluster_index = IDX_W'($urandom_range(0, lim - 1));
				end else if (r < 85) begin
					word.cluster_index = IDX_W'(lim + $urandom_range(0, 3));
				end else begin
					word.cluster_index = IDX_W'($urandom);
				end
				idle_gap((p == 3) ? 0 : pick_gap());
				send_word(word, 1'b0, '0);
			end
		end

		start <= 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_grants.size() == 0)
			$display("bitmap_cluster_allocator: match");
		else
			$display("bitmap_cluster_allocator: mismatch");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/bca_pkg.sv
rtl/bca_datapath.sv
rtl/bca_controller.sv
rtl/bitmap_cluster_allocator.sv
tb/bitmap_cluster_allocator_tb.sv
